>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for block-level checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition must never be seen at a clock edge outside reset
`define CHK_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

>>> hdl/cllc_pkg.sv
// ----------------------------------------------------------------------------
// cllc_pkg
// Shared types and constants of the circular list cursor engine
// ----------------------------------------------------------------------------
package cllc_pkg;

  // default sizes
  localparam int POOL_NODES_DEF  = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  // fixed field widths
  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 2;
  localparam int ITEM_W   = 32;

  // request opcodes
  typedef enum logic [FUNC_W-1:0] {
    FN_INS_TAIL  = 3'd0,
    FN_INS_FRONT = 3'd1,
    FN_FIRST     = 3'd2,
    FN_NEXT      = 3'd3,
    FN_REMOVE    = 3'd4,
    FN_COUNT     = 3'd5
  } func_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NO_CURSOR = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    FS_IDLE,
    FS_INS_LINK,
    FS_INS_PATCH,
    FS_NAV_LINK,
    FS_NAV_VALUE,
    FS_REM
  } fsm_t;

endpackage

>>> hdl/circular_list_cursor_engine.sv
// ----------------------------------------------------------------------------
// circular_list_cursor_engine: circular linked list in a node pool RAM pair
// Results: count, full, error and first-node insert straight from idle; remove
// via FS_REM; non-empty insert, first and next via a link read, then a value read
// or link write state. One request at a time; busy is high outside idle.
// Synchronous active-low reset empties the list and frees every slot.
// ----------------------------------------------------------------------------
module circular_list_cursor_engine import cllc_pkg::*; #(
  parameter int POOL_NODES  = POOL_NODES_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int IDX_W      = $clog2(POOL_NODES),
  localparam int CNT_W      = $clog2(POOL_NODES + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic        [FUNC_W-1:0]   in_func,
  input  logic signed [ITEM_W-1:0]   in_item_value,
  output logic                       out_valid,
  output logic        [STATUS_W-1:0] out_status,
  output logic signed [ITEM_W-1:0]   out_value_out,
  output logic        [CNT_W-1:0]    out_entries
);

  // sequencer and list state
  fsm_t                  state_r, state_nxt;
  logic                  at_tail_r, at_tail_nxt;
  logic [IDX_W-1:0]      new_r, new_nxt;
  logic [POOL_NODES-1:0] free_r, free_nxt;
  logic [IDX_W-1:0]      tail_r, tail_nxt;
  logic                  nonempty_r, nonempty_nxt;
  logic [IDX_W-1:0]      cur_r, cur_nxt;
  logic [IDX_W-1:0]      prev_r, prev_nxt;
  logic                  cv_r, cv_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [ITEM_W-1:0]     out_value_r, out_value_nxt;
  logic [CNT_W-1:0]      out_entries_r, out_entries_nxt;

  // node pool memory ports
  logic                   val_we;
  logic [IDX_W-1:0]       val_waddr, val_raddr;
  logic [VALUE_WIDTH-1:0] val_wdata, val_rdata;
  logic                   link_we;
  logic [IDX_W-1:0]       link_waddr, link_raddr;
  logic [IDX_W-1:0]       link_wdata, link_rdata;

  // free slot search
  logic [IDX_W-1:0]       free_slot;
  logic                   has_free;

  cllc_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (POOL_NODES)
  ) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  cllc_ram #(
    .WIDTH (IDX_W),
    .DEPTH (POOL_NODES)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  // lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = POOL_NODES - 1; i >= 0; i--) begin
      if (free_r[i]) begin
        free_slot = IDX_W'(i);
      end
    end
  end

  assign has_free = |free_r;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FS_IDLE;
      free_r      <= '1;
      tail_r      <= '0;
      nonempty_r  <= 1'b0;
      cur_r       <= '0;
      prev_r      <= '0;
      cv_r        <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_r      <= free_nxt;
      tail_r      <= tail_nxt;
      nonempty_r  <= nonempty_nxt;
      cur_r       <= cur_nxt;
      prev_r      <= prev_nxt;
      cv_r        <= cv_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    at_tail_r     <= at_tail_nxt;
    new_r         <= new_nxt;
    out_status_r  <= out_status_nxt;
    out_value_r   <= out_value_nxt;
    out_entries_r <= out_entries_nxt;
  end

  // next state, memory requests and results; the sequencer never reads
  // an entry in the cycle it writes it, so no forwarding is needed
  always_comb begin
    state_nxt       = state_r;
    at_tail_nxt     = at_tail_r;
    new_nxt         = new_r;
    free_nxt        = free_r;
    tail_nxt        = tail_r;
    nonempty_nxt    = nonempty_r;
    cur_nxt         = cur_r;
    prev_nxt        = prev_r;
    cv_nxt          = cv_r;
    count_nxt       = count_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    out_value_nxt   = out_value_r;
    out_entries_nxt = out_entries_r;
    val_we          = 1'b0;
    val_waddr       = '0;
    val_wdata       = VALUE_WIDTH'(in_item_value);
    val_raddr       = '0;
    link_we         = 1'b0;
    link_waddr      = '0;
    link_wdata      = '0;
    link_raddr      = '0;

    unique case (state_r)
      FS_IDLE: begin
        if (start) begin
          // immediate result unless a memory pass is launched below
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_OK;
          out_value_nxt   = '0;
          out_entries_nxt = count_r;
          unique case (func_t'(in_func))
            FN_INS_TAIL, FN_INS_FRONT: begin
              if (!has_free) begin
                out_status_nxt = ST_FULL;
              end else begin
                val_we      = 1'b1;
                val_waddr   = free_slot;
                new_nxt     = free_slot;
                at_tail_nxt = (func_t'(in_func) == FN_INS_TAIL);
                if (!nonempty_r) begin
                  // first node links to itself
                  link_we             = 1'b1;
                  link_waddr          = free_slot;
                  link_wdata          = free_slot;
                  tail_nxt            = free_slot;
                  nonempty_nxt        = 1'b1;
                  free_nxt[free_slot] = 1'b0;
                  count_nxt           = count_r + CNT_W'(1);
                  out_entries_nxt     = count_r + CNT_W'(1);
                end else begin
                  link_raddr    = tail_r;
                  out_valid_nxt = 1'b0;
                  state_nxt     = FS_INS_LINK;
                end
              end
            end
            FN_FIRST: begin
              if (!nonempty_r) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                link_raddr    = tail_r;
                prev_nxt      = tail_r;
                out_valid_nxt = 1'b0;
                state_nxt     = FS_NAV_LINK;
              end
            end
            FN_NEXT: begin
              if (!nonempty_r) begin
                out_status_nxt = ST_EMPTY;
              end else if (!cv_r) begin
                out_status_nxt = ST_NO_CURSOR;
              end else begin
                link_raddr    = cur_r;
                prev_nxt      = cur_r;
                out_valid_nxt = 1'b0;
                state_nxt     = FS_NAV_LINK;
              end
            end
            FN_REMOVE: begin
              if (!nonempty_r) begin
                out_status_nxt = ST_EMPTY;
              end else if (!cv_r || (cur_r == prev_r && count_r > CNT_W'(1))) begin
                // no cursor, or a repeated remove
                out_status_nxt = ST_NO_CURSOR;
              end else begin
                link_raddr    = cur_r;
                val_raddr     = cur_r;
                out_valid_nxt = 1'b0;
                state_nxt     = FS_REM;
              end
            end
            default: begin
              // count and unused codes report the node count
            end
          endcase
        end
      end

      // tail link arrives: new node takes it over
      FS_INS_LINK: begin
        link_we    = 1'b1;
        link_waddr = new_r;
        link_wdata = link_rdata;
        if (cv_r && prev_r == tail_r && link_rdata == cur_r) begin
          prev_nxt = new_r;
        end
        state_nxt = FS_INS_PATCH;
      end

      // splice new node behind the tail
      FS_INS_PATCH: begin
        link_we         = 1'b1;
        link_waddr      = tail_r;
        link_wdata      = new_r;
        if (at_tail_r) begin
          tail_nxt = new_r;
        end
        free_nxt[new_r] = 1'b0;
        count_nxt       = count_r + CNT_W'(1);
        out_valid_nxt   = 1'b1;
        out_status_nxt  = ST_OK;
        out_value_nxt   = '0;
        out_entries_nxt = count_r + CNT_W'(1);
        state_nxt       = FS_IDLE;
      end

      // successor found: move cursor and fetch its value
      FS_NAV_LINK: begin
        cur_nxt   = link_rdata;
        val_raddr = link_rdata;
        state_nxt = FS_NAV_VALUE;
      end

      FS_NAV_VALUE: begin
        cv_nxt          = 1'b1;
        out_valid_nxt   = 1'b1;
        out_status_nxt  = ST_OK;
        out_value_nxt   = ITEM_W'(val_rdata);
        out_entries_nxt = count_r;
        state_nxt       = FS_IDLE;
      end

      // unlink the cursor node
      FS_REM: begin
        free_nxt[cur_r] = 1'b1;
        count_nxt       = count_r - CNT_W'(1);
        out_valid_nxt   = 1'b1;
        out_status_nxt  = ST_OK;
        out_value_nxt   = ITEM_W'(val_rdata);
        out_entries_nxt = count_r - CNT_W'(1);
        if (count_r == CNT_W'(1)) begin
          nonempty_nxt = 1'b0;
          cv_nxt       = 1'b0;
          tail_nxt     = '0;
          cur_nxt      = '0;
          prev_nxt     = '0;
        end else begin
          if (cur_r == tail_r) begin
            tail_nxt = prev_r;
          end
          link_we    = 1'b1;
          link_waddr = prev_r;
          link_wdata = link_rdata;
          cur_nxt    = prev_r;
        end
        state_nxt = FS_IDLE;
      end

      default: begin
        state_nxt = FS_IDLE;
      end
    endcase
  end

  // outputs
  assign busy          = (state_r != FS_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value_out = out_value_r;
  assign out_entries   = out_entries_r;

endmodule

>>> hdl/cllc_ram.sv
// ----------------------------------------------------------------------------
// cllc_ram
// Generic simple dual-port RAM, one write port, one registered read port
// ----------------------------------------------------------------------------
module cllc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/cllc_checker.sv
// ----------------------------------------------------------------------------
// cllc_checker
// Port-level assertions for the circular list cursor engine, bound to the top
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cllc_checker import cllc_pkg::*; #(
  parameter int POOL_NODES = POOL_NODES_DEF,
  localparam int CNT_W     = $clog2(POOL_NODES + 1)
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic [FUNC_W-1:0]   in_func,
  input logic                out_valid,
  input logic [STATUS_W-1:0] out_status,
  input logic [CNT_W-1:0]    out_entries
);

  // an accepted request either keeps the engine busy or returns at once
  `CHK_ASSERT(a_accept_progress, clk, rst_n, start && !busy |=> busy || out_valid, "accepted request made no progress")

  // a result ends the request, so it never shows while busy
  `CHK_NEVER(a_result_idle, clk, rst_n, out_valid && busy, "result strobe while busy")

  // count requests answer next cycle with ok
  `CHK_ASSERT(a_count_reply, clk, rst_n, start && !busy && in_func == FN_COUNT |=> out_valid && out_status == ST_OK, "count request not answered next cycle")

  // pool full only when every slot is in the list
  `CHK_ASSERT(a_full_count, clk, rst_n, out_valid && out_status == ST_FULL |-> out_entries == CNT_W'(POOL_NODES), "pool full with free slots left")

  // empty status only with no nodes
  `CHK_ASSERT(a_empty_count, clk, rst_n, out_valid && out_status == ST_EMPTY |-> out_entries == '0, "list empty reported with nodes present")

endmodule

bind circular_list_cursor_engine cllc_checker #(
  .POOL_NODES (POOL_NODES)
) u_cllc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_func     (in_func),
  .out_valid   (out_valid),
  .out_status  (out_status),
  .out_entries (out_entries)
);

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: circular list cursor engine testbench
// Runs a directed table of list operations, then random phases that fill,
// walk and drain the node pool or send random codes. Every result transfer is
// compared per field with the table or an in-bench list, pool and cursor model.
// ----------------------------------------------------------------------------
module tb;
  import cllc_pkg::*;

  localparam int NODES      = 16;
  localparam int RAND_OPS   = 950;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = 10;

  // codes outside the defined set behave like count
  localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;

  // random phase kinds
  typedef enum int {PH_FILL, PH_DRAIN, PH_WALK, PH_NOISE} phase_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ITEM_W-1:0]   value;
    logic [4:0]          entries;
  } list_result_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ITEM_W-1:0] value;
    bit                typed;
    list_result_t      res;
  } op_row_t;

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              start         = 1'b0;
  logic [FUNC_W-1:0] in_func       = '0;
  logic [ITEM_W-1:0] in_item_value = '0;
  logic              busy;
  logic              out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [ITEM_W-1:0] out_value_out;
  logic [4:0]        out_entries;

  // list model state
  logic [ITEM_W-1:0] node_val  [NODES];
  logic [3:0]        node_next [NODES];
  logic [NODES-1:0]  free_slots = '1;
  logic [3:0]        tail_idx   = '0;
  logic [3:0]        cur_idx    = '0;
  logic [3:0]        prev_idx   = '0;
  logic              has_nodes  = 1'b0;
  logic              cur_ok     = 1'b0;
  logic [4:0]        node_total = '0;

  list_result_t pending_results[$];
  op_row_t      op_table[$];
  int           mismatch_count = 0;
  int           idle_cycles    = 0;

  circular_list_cursor_engine uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_item_value (in_item_value),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_value_out (out_value_out),
    .out_entries   (out_entries)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // lowest free slot, -1 when the pool is full
  function automatic int lowest_free();
    for (int i = 0; i < NODES; i++)
      if (free_slots[i]) return i;
    return -1;
  endfunction

  // applies one operation to the list model and returns its result
  function automatic list_result_t apply_list_op(logic [FUNC_W-1:0] f,
                                                 logic [ITEM_W-1:0] v);
    list_result_t r;
    int           slot;
    logic [3:0]   n;
    bit           between;
    r = '{status: ST_OK, value: '0, entries: '0};
    case (f)
      FN_INS_TAIL, FN_INS_FRONT: begin
        slot = lowest_free();
        if (slot < 0) begin
          r.status = ST_FULL;
        end else begin
          n = slot[3:0];
          free_slots[n] = 1'b0;
          node_val[n] = v;
          if (!has_nodes) begin
            node_next[n] = n;
            tail_idx = n;
            has_nodes = 1'b1;
          end else begin
            // new node between predecessor and cursor takes over as predecessor
            between = cur_ok && prev_idx == tail_idx && node_next[prev_idx] == cur_idx;
            node_next[n] = node_next[tail_idx];
            node_next[tail_idx] = n;
            if (between) prev_idx = n;
            if (f == FN_INS_TAIL) tail_idx = n;
          end
          node_total++;
        end
      end
      FN_FIRST: begin
        if (!has_nodes) begin
          r.status = ST_EMPTY;
        end else begin
          prev_idx = tail_idx;
          cur_idx = node_next[prev_idx];
          cur_ok = 1'b1;
          r.value = node_val[cur_idx];
        end
      end
      FN_NEXT: begin
        if (!has_nodes) begin
          r.status = ST_EMPTY;
        end else if (!cur_ok) begin
          r.status = ST_NO_CURSOR;
        end else begin
          prev_idx = cur_idx;
          cur_idx = node_next[prev_idx];
          r.value = node_val[cur_idx];
        end
      end
      FN_REMOVE: begin
        if (!has_nodes) begin
          r.status = ST_EMPTY;
        end else if (!cur_ok || (cur_idx == prev_idx && node_total > 1)) begin
          r.status = ST_NO_CURSOR;
        end else begin
          r.value = node_val[cur_idx];
          free_slots[cur_idx] = 1'b1;
          node_total--;
          if (node_total == 0) begin
            has_nodes = 1'b0;
            cur_ok = 1'b0;
            tail_idx = '0;
            cur_idx = '0;
            prev_idx = '0;
          end else begin
            if (cur_idx == tail_idx) tail_idx = prev_idx;
            node_next[prev_idx] = node_next[cur_idx];
            cur_idx = prev_idx;
          end
        end
      end
      default: ;
    endcase
    r.entries = node_total;
    return r;
  endfunction

  // one request transfer, then an optional hold-off with start low
  task automatic send_op(input logic [FUNC_W-1:0] f, input logic [ITEM_W-1:0] v,
                         input bit typed, input list_result_t typed_res,
                         input int unsigned gap);
    list_result_t pred;
    start <= 1'b1;
    in_func <= f;
    in_item_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = apply_list_op(f, v);
    pending_results.push_back(typed ? typed_res : pred);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending until every outstanding result has come back
  task automatic wait_results_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input logic [FUNC_W-1:0] f, input logic [ITEM_W-1:0] v,
                         input bit typed, input logic [STATUS_W-1:0] st,
                         input logic [ITEM_W-1:0] vo, input logic [4:0] cnt);
    op_table.push_back('{func: f, value: v, typed: typed,
                         res: '{status: st, value: vo, entries: cnt}});
  endtask

  // gap after a transfer: mostly none or short, a few long
  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [ITEM_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // operation mix per phase kind
  function automatic logic [FUNC_W-1:0] pick_func(phase_t ph);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (ph)
      PH_FILL: begin
        if (r < 35) return FN_INS_TAIL;
        if (r < 60) return FN_INS_FRONT;
        if (r < 75) return FN_FIRST;
        if (r < 90) return FN_NEXT;
        return FN_REMOVE;
      end
      PH_DRAIN: begin
        if (r < 8)  return FN_INS_TAIL;
        if (r < 15) return FN_INS_FRONT;
        if (r < 30) return FN_FIRST;
        if (r < 55) return FN_NEXT;
        return FN_REMOVE;
      end
      PH_WALK: begin
        if (r < 10) return FN_INS_TAIL;
        if (r < 20) return FN_INS_FRONT;
        if (r < 35) return FN_FIRST;
        if (r < 75) return FN_NEXT;
        if (r < 90) return FN_REMOVE;
        return FN_COUNT;
      end
      default: return FUNC_W'($urandom_range(0, 7));
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: status %0d value %h entries %0d",
               out_status, out_value_out, out_entries);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatch_count++;
        end
        if (out_value_out !== want.value) begin
          $error("value_out: expected %h, got %h", want.value, out_value_out);
          mismatch_count++;
        end
        if (out_entries !== want.entries) begin
          $error("entries: expected %0d, got %0d", want.entries, out_entries);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  initial begin : stimulus
    phase_t      ph;
    int          phase_left;
    bit          quiet;
    list_result_t no_res;
    no_res = '0;

    // directed table: empty list errors, single node, cursor edge cases
    add_row(FN_COUNT,     32'h0,         1, ST_OK,        32'h0,         5'd0);
    add_row(FN_FIRST,     32'h0,         1, ST_EMPTY,     32'h0,         5'd0);
    add_row(FN_NEXT,      32'h0,         1, ST_EMPTY,     32'h0,         5'd0);
    add_row(FN_REMOVE,    32'h0,         1, ST_EMPTY,     32'h0,         5'd0);
    add_row(FN_INS_TAIL,  32'h7fff_ffff, 1, ST_OK,        32'h0,         5'd1);
    add_row(FN_NEXT,      32'h0,         1, ST_NO_CURSOR, 32'h0,         5'd1);
    add_row(FN_REMOVE,    32'h0,         1, ST_NO_CURSOR, 32'h0,         5'd1);
    add_row(FN_FIRST,     32'h0,         1, ST_OK,        32'h7fff_ffff, 5'd1);
    add_row(FN_NEXT,      32'h0,         1, ST_OK,        32'h7fff_ffff, 5'd1);
    add_row(FN_REMOVE,    32'h0,         1, ST_OK,        32'h7fff_ffff, 5'd0);
    add_row(FN_NEXT,      32'h0,         1, ST_EMPTY,     32'h0,         5'd0);
    add_row(FN_INS_FRONT, 32'h8000_0000, 1, ST_OK,        32'h0,         5'd1);
    add_row(FN_INS_TAIL,  32'h0000_0001, 1, ST_OK,        32'h0,         5'd2);
    add_row(FN_FIRST,     32'h0,         1, ST_OK,        32'h8000_0000, 5'd2);
    // insert lands between predecessor and cursor
    add_row(FN_INS_TAIL,  32'h0,         0, ST_OK, 32'h0, 5'd0);
    add_row(FN_INS_FRONT, 32'hffff_ffff, 0, ST_OK, 32'h0, 5'd0);
    add_row(FN_NEXT,      32'h0,         0, ST_OK, 32'h0, 5'd0);
    add_row(FN_REMOVE,    32'h0,         0, ST_OK, 32'h0, 5'd0);
    // second remove in a row has no cursor
    add_row(FN_REMOVE,    32'h0,         1, ST_NO_CURSOR, 32'h0,         5'd3);
    add_row(FN_NEXT,      32'h0,         0, ST_OK, 32'h0, 5'd0);
    add_row(FN_SPARE_A,   32'h1234_5678, 1, ST_OK,        32'h0,         5'd3);
    add_row(FN_SPARE_B,   32'hffff_ffff, 1, ST_OK,        32'h0,         5'd3);
    add_row(FN_COUNT,     32'h0,         1, ST_OK,        32'h0,         5'd3);
    add_row(FN_INS_TAIL,  32'h5555_5555, 0, ST_OK, 32'h0, 5'd0);
    add_row(FN_INS_FRONT, 32'haaaa_aaaa, 0, ST_OK, 32'h0, 5'd0);

    // reset
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (op_table[i])
      send_op(op_table[i].func, op_table[i].value, op_table[i].typed,
              op_table[i].res, pick_gap(i < 8));
    wait_results_drained();

    // random phases
    ph = PH_FILL;
    phase_left = 0;
    quiet = 1'b0;
    for (int k = 0; k < RAND_OPS; k++) begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2: ph = PH_FILL;
          3, 4, 5: ph = PH_DRAIN;
          6, 7, 8: ph = PH_WALK;
          default: ph = PH_NOISE;
        endcase
        phase_left = $urandom_range(10, 40);
        quiet = ($urandom_range(0, 3) == 0);
      end
      phase_left--;
      send_op(pick_func(ph), pick_value(), 0, no_res, pick_gap(quiet));
      if ($urandom_range(0, 49) == 0) wait_results_drained();
    end

    // drain and finish
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
